// File: hdl/ucs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucs_pkg
// Shared types, codes and helpers for the update campaign sequencer.
// ----------------------------------------------------------------------------
package ucs_pkg;

  // Transaction opcodes (codes six and seven are unused and ignored)
  typedef enum logic [2:0] {
    OP_START     = 3'd0,
    OP_BYTE      = 3'd1,
    OP_FETCH_END = 3'd2,
    OP_ADVANCE   = 3'd3,
    OP_FINISH    = 3'd4,
    OP_QUERY     = 3'd5
  } op_t;

  // Campaign phase
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_FETCHING = 3'd1,
    PH_READY    = 3'd2,
    PH_SENDING  = 3'd3,
    PH_DONE     = 3'd4,
    PH_ERROR    = 3'd5
  } phase_t;

  // Result status
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_INVALID     = 3'd1,
    ST_BUSY        = 3'd2,
    ST_TOO_BIG     = 3'd3,
    ST_IO          = 3'd4,
    ST_NOT_PENDING = 3'd5,
    ST_IGNORED     = 3'd6
  } status_t;

  // Field widths
  localparam int unsigned MASK_W  = 32;
  localparam int unsigned SIZE_W  = 24;
  localparam int unsigned COUNT_W = 25;
  localparam int unsigned CRC_W   = 16;
  localparam int unsigned NODE_W  = 6;
  localparam int unsigned NID_W   = 5;

  // Checkpoint span is 16384 bytes: the low bits of progress give the offset
  localparam int unsigned SPAN_BITS = 14;

  localparam logic [23:0]      CAPACITY_RST = 24'd1048576;
  localparam logic [COUNT_W-1:0] STAGED_MAX = {COUNT_W{1'b1}};
  localparam logic [CRC_W-1:0]   CRC_POLY   = 16'h1021;

  // Handshake commands from controller to datapath
  typedef struct packed {
    logic capture;  // register the accepted input transaction
    logic execute;  // apply the held transaction and load the result
  } ucs_cmd_t;

  // CRC-16, MSB first, one byte folded in
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0]       data);
    logic [CRC_W-1:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/ucs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucs_ctrl
// Handshake controller: takes one transaction, runs it once the result
// register is free, and keeps the result valid until it is taken.
// ----------------------------------------------------------------------------
module ucs_ctrl
  import ucs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output ucs_cmd_t cmd
);

  typedef enum logic {
    S_WAIT,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // Result register can take a new result this cycle
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cmd.capture   = 1'b0;
    cmd.execute   = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_WAIT: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.execute   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_WAIT;
        end
      end
      default: begin
        state_nxt = S_WAIT;
      end
    endcase
  end

  // Hold state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_WAIT);
  assign out_valid = out_valid_r;

endmodule

// File: hdl/ucs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucs_dp
// Campaign datapath: input register, campaign state, byte CRC and count,
// target priority encoder and result register.
// ----------------------------------------------------------------------------
module ucs_dp
  import ucs_pkg::*;
#(
  parameter int unsigned MAX_NODES = 32,
  parameter int unsigned CHUNK_MAX = 192
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ucs_cmd_t            cmd,
  input  logic                cfg_wr,
  input  logic [SIZE_W-1:0]   cfg_data,
  input  logic [2:0]          in_op,
  input  logic [MASK_W-1:0]   in_target_mask,
  input  logic [SIZE_W-1:0]   in_image_size,
  input  logic [7:0]          in_data_byte,
  input  logic [SIZE_W-1:0]   in_progress,
  input  logic                in_success,
  input  logic [NID_W-1:0]    in_node_id,
  output logic [2:0]          out_status,
  output logic [2:0]          out_campaign_state,
  output logic [NODE_W-1:0]   out_current_node,
  output logic                out_pending,
  output logic [SIZE_W-1:0]   out_size_out,
  output logic [CRC_W-1:0]    out_crc_out,
  output logic [SIZE_W-1:0]   out_sent_out,
  output logic                out_save_request,
  output logic [MASK_W-1:0]   out_done_out,
  output logic [MASK_W-1:0]   out_failed_out,
  output logic [MASK_W-1:0]   out_remaining_out
);

  localparam logic [MASK_W-1:0] NODE_SPACE =
    MASK_W'((64'd1 << MAX_NODES) - 64'd1);
  localparam logic [NODE_W-1:0]   NODE_NONE = NODE_W'(MAX_NODES);
  localparam logic [SPAN_BITS:0]  CHUNK_LIM = (SPAN_BITS + 1)'(CHUNK_MAX);

  // Held transaction
  logic [2:0]        op_r;
  logic [MASK_W-1:0] mask_r;
  logic [SIZE_W-1:0] size_r;
  logic [7:0]        byte_r;
  logic [SIZE_W-1:0] prog_r;
  logic              ok_r;
  logic [NID_W-1:0]  nid_r;

  // Campaign state
  logic [SIZE_W-1:0]  capacity_r;
  phase_t             phase_r, phase_nxt;
  logic [MASK_W-1:0]  remaining_r, remaining_nxt;
  logic [MASK_W-1:0]  accepted_r, accepted_nxt;
  logic [MASK_W-1:0]  refused_r, refused_nxt;
  logic [NODE_W-1:0]  serving_r, serving_nxt;
  logic [SIZE_W-1:0]  announced_r, announced_nxt;
  logic [CRC_W-1:0]   latched_crc_r, latched_crc_nxt;
  logic [SIZE_W-1:0]  delivered_r, delivered_nxt;
  logic [CRC_W-1:0]   running_crc_r, running_crc_nxt;
  logic [COUNT_W-1:0] staged_r, staged_nxt;

  // Result register
  status_t            status_r, status_nxt;
  phase_t             res_phase_r;
  logic [NODE_W-1:0]  res_node_r;
  logic               pend_r, pend_nxt;
  logic [SIZE_W-1:0]  res_size_r;
  logic [CRC_W-1:0]   res_crc_r;
  logic [SIZE_W-1:0]  res_sent_r;
  logic               save_r, save_nxt;
  logic [MASK_W-1:0]  res_done_r;
  logic [MASK_W-1:0]  res_failed_r;
  logic [MASK_W-1:0]  res_remaining_r;

  logic              active;
  logic              start_bad;
  logic [MASK_W-1:0] serve_bit;
  logic [MASK_W-1:0] search_mask;
  logic              pick_found;
  logic [NID_W-1:0]  pick_id;

  assign active    = (phase_r == PH_READY) || (phase_r == PH_SENDING);
  assign start_bad = (size_r == '0) || (mask_r == '0) || ((mask_r & ~NODE_SPACE) != '0);
  assign serve_bit = (serving_r < NODE_NONE) ? (MASK_W'(1) << serving_r) : '0;

  // Finish searches the targets left after dropping the current node
  assign search_mask = (op_t'(op_r) == OP_FINISH) ? (remaining_r & ~serve_bit) : remaining_r;

  // Priority encoder: lowest pending target
  always_comb begin
    pick_found = 1'b0;
    pick_id    = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (search_mask[i]) begin
        pick_found = 1'b1;
        pick_id    = NID_W'(i);
      end
    end
  end

  // Apply the held transaction
  always_comb begin
    phase_nxt       = phase_r;
    remaining_nxt   = remaining_r;
    accepted_nxt    = accepted_r;
    refused_nxt     = refused_r;
    serving_nxt     = serving_r;
    announced_nxt   = announced_r;
    latched_crc_nxt = latched_crc_r;
    delivered_nxt   = delivered_r;
    running_crc_nxt = running_crc_r;
    staged_nxt      = staged_r;
    status_nxt      = ST_IGNORED;
    pend_nxt        = 1'b0;
    save_nxt        = 1'b0;
    unique case (op_t'(op_r))
      OP_START: begin
        if (start_bad) begin
          status_nxt = ST_INVALID;
        end else if (phase_r == PH_FETCHING || phase_r == PH_SENDING) begin
          status_nxt = ST_BUSY;
        end else if (size_r > capacity_r) begin
          status_nxt = ST_TOO_BIG;
        end else begin
          phase_nxt       = PH_FETCHING;
          remaining_nxt   = mask_r;
          accepted_nxt    = '0;
          refused_nxt     = '0;
          serving_nxt     = NODE_NONE;
          announced_nxt   = size_r;
          delivered_nxt   = '0;
          running_crc_nxt = '0;
          staged_nxt      = '0;
          save_nxt        = 1'b1;
          status_nxt      = ST_OK;
        end
      end
      OP_BYTE: begin
        if (phase_r == PH_FETCHING) begin
          running_crc_nxt = crc16_byte(running_crc_r, byte_r);
          if (staged_r != STAGED_MAX) begin
            staged_nxt = staged_r + COUNT_W'(1);
          end
          status_nxt = ST_OK;
        end
      end
      OP_FETCH_END: begin
        if (phase_r == PH_FETCHING) begin
          save_nxt = 1'b1;
          if (!ok_r) begin
            phase_nxt  = PH_ERROR;
            status_nxt = ST_IO;
          end else if (staged_r != {1'b0, announced_r}) begin
            phase_nxt  = PH_ERROR;
            status_nxt = ST_INVALID;
          end else begin
            latched_crc_nxt = running_crc_r;
            status_nxt      = ST_OK;
            if (pick_found) begin
              serving_nxt   = {1'b0, pick_id};
              delivered_nxt = '0;
              phase_nxt     = PH_READY;
            end else begin
              phase_nxt = (refused_r == '0) ? PH_DONE : PH_ERROR;
            end
          end
        end
      end
      OP_ADVANCE: begin
        if (active && (prog_r > delivered_r)) begin
          delivered_nxt = prog_r;
          phase_nxt     = PH_SENDING;
          status_nxt    = ST_OK;
          if ({1'b0, prog_r[SPAN_BITS-1:0]} < CHUNK_LIM || prog_r == announced_r) begin
            save_nxt = 1'b1;
          end
        end
      end
      OP_FINISH: begin
        if (active) begin
          remaining_nxt = remaining_r & ~serve_bit;
          if (ok_r) begin
            accepted_nxt = accepted_r | serve_bit;
          end else begin
            refused_nxt = refused_r | serve_bit;
          end
          save_nxt   = 1'b1;
          status_nxt = ST_OK;
          if (pick_found) begin
            serving_nxt   = {1'b0, pick_id};
            delivered_nxt = '0;
            phase_nxt     = PH_READY;
          end else begin
            phase_nxt = ((refused_r | (ok_r ? '0 : serve_bit)) == '0) ? PH_DONE : PH_ERROR;
          end
        end
      end
      OP_QUERY: begin
        pend_nxt   = active && (serving_r == {1'b0, nid_r});
        status_nxt = pend_nxt ? ST_OK : ST_NOT_PENDING;
      end
      default: begin
        status_nxt = ST_IGNORED;
      end
    endcase
  end

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      mask_r <= in_target_mask;
      size_r <= in_image_size;
      byte_r <= in_data_byte;
      prog_r <= in_progress;
      ok_r   <= in_success;
      nid_r  <= in_node_id;
    end
  end

  // Campaign state and staging capacity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r    <= CAPACITY_RST;
      phase_r       <= PH_IDLE;
      remaining_r   <= '0;
      accepted_r    <= '0;
      refused_r     <= '0;
      serving_r     <= '0;
      announced_r   <= '0;
      latched_crc_r <= '0;
      delivered_r   <= '0;
      running_crc_r <= '0;
      staged_r      <= '0;
    end else begin
      if (cfg_wr) begin
        capacity_r <= cfg_data;
      end
      if (cmd.execute) begin
        phase_r       <= phase_nxt;
        remaining_r   <= remaining_nxt;
        accepted_r    <= accepted_nxt;
        refused_r     <= refused_nxt;
        serving_r     <= serving_nxt;
        announced_r   <= announced_nxt;
        latched_crc_r <= latched_crc_nxt;
        delivered_r   <= delivered_nxt;
        running_crc_r <= running_crc_nxt;
        staged_r      <= staged_nxt;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status_r        <= status_nxt;
      res_phase_r     <= phase_nxt;
      res_node_r      <= serving_nxt;
      pend_r          <= pend_nxt;
      res_size_r      <= announced_nxt;
      res_crc_r       <= latched_crc_nxt;
      res_sent_r      <= delivered_nxt;
      save_r          <= save_nxt;
      res_done_r      <= accepted_nxt;
      res_failed_r    <= refused_nxt;
      res_remaining_r <= remaining_nxt;
    end
  end

  assign out_status         = status_r;
  assign out_campaign_state = res_phase_r;
  assign out_current_node   = res_node_r;
  assign out_pending        = pend_r;
  assign out_size_out       = res_size_r;
  assign out_crc_out        = res_crc_r;
  assign out_sent_out       = res_sent_r;
  assign out_save_request   = save_r;
  assign out_done_out       = res_done_r;
  assign out_failed_out     = res_failed_r;
  assign out_remaining_out  = res_remaining_r;

endmodule

// File: hdl/update_campaign_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// update_campaign_sequencer_core
// Sequences delivery of one image to a set of target nodes.
// ----------------------------------------------------------------------------
// Each transaction is first registered, then applied to the campaign state
// while the result register is loaded; a new transaction is taken only once
// the held one has been applied. The result register lets the next
// transaction be accepted while a result still waits; a held transaction is
// applied only once that register is free. The CRC of an image byte is folded
// in as the byte is applied. cfg_ready is always high; write staging_capacity
// only while no transaction is in flight.
// ----------------------------------------------------------------------------
module update_campaign_sequencer_core
  import ucs_pkg::*;
#(
  parameter int unsigned MAX_NODES = 32,
  parameter int unsigned CHUNK_MAX = 192
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SIZE_W-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_op,
  input  logic [MASK_W-1:0]   in_target_mask,
  input  logic [SIZE_W-1:0]   in_image_size,
  input  logic [7:0]          in_data_byte,
  input  logic [SIZE_W-1:0]   in_progress,
  input  logic                in_success,
  input  logic [NID_W-1:0]    in_node_id,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_status,
  output logic [2:0]          out_campaign_state,
  output logic [NODE_W-1:0]   out_current_node,
  output logic                out_pending,
  output logic [SIZE_W-1:0]   out_size_out,
  output logic [CRC_W-1:0]    out_crc_out,
  output logic [SIZE_W-1:0]   out_sent_out,
  output logic                out_save_request,
  output logic [MASK_W-1:0]   out_done_out,
  output logic [MASK_W-1:0]   out_failed_out,
  output logic [MASK_W-1:0]   out_remaining_out
);

  ucs_cmd_t cmd;

  assign cfg_ready = 1'b1;

  // Handshake controller
  ucs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Campaign datapath
  ucs_dp #(
    .MAX_NODES (MAX_NODES),
    .CHUNK_MAX (CHUNK_MAX)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg_wr             (cfg_valid && cfg_ready),
    .cfg_data           (cfg_data),
    .in_op              (in_op),
    .in_target_mask     (in_target_mask),
    .in_image_size      (in_image_size),
    .in_data_byte       (in_data_byte),
    .in_progress        (in_progress),
    .in_success         (in_success),
    .in_node_id         (in_node_id),
    .out_status         (out_status),
    .out_campaign_state (out_campaign_state),
    .out_current_node   (out_current_node),
    .out_pending        (out_pending),
    .out_size_out       (out_size_out),
    .out_crc_out        (out_crc_out),
    .out_sent_out       (out_sent_out),
    .out_save_request   (out_save_request),
    .out_done_out       (out_done_out),
    .out_failed_out     (out_failed_out),
    .out_remaining_out  (out_remaining_out)
  );

endmodule

// File: hdl/ucs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucs_checker
// Port-level checks on the sequencer's result channel.
// ----------------------------------------------------------------------------
module ucs_checker
  import ucs_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [2:0]        out_status,
  input logic [2:0]        out_campaign_state,
  input logic              out_pending,
  input logic [MASK_W-1:0] out_done_out,
  input logic [MASK_W-1:0] out_failed_out,
  input logic [MASK_W-1:0] out_remaining_out
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_done_out))
    else $error("stalled result changed");

  // Raise pending only with an ok status
  a_pend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pending |-> out_status == ST_OK)
    else $error("pending without ok status");

  // Busy refusals only come while fetching or sending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_BUSY |->
      out_campaign_state == PH_FETCHING || out_campaign_state == PH_SENDING)
    else $error("busy reported in a free phase");

  // Keep done, failed and remaining masks disjoint
  a_masks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_done_out & out_failed_out) == '0 &&
                  ((out_done_out | out_failed_out) & out_remaining_out) == '0)
    else $error("node masks overlap");

endmodule

bind update_campaign_sequencer_core ucs_checker u_chk (.*);

// File: dv/update_campaign_sequencer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// update_campaign_sequencer_core_tb
// Self-checking bench for the update campaign sequencer. A directed opening
// covers refusals, ignored transactions and one complete campaign. Random
// campaigns follow under several staging capacities and idle patterns on
// both channels. A scoreboard predicts every result and compares each
// result field with the oldest prediction.
// ----------------------------------------------------------------------------
module update_campaign_sequencer_core_tb;
  import ucs_pkg::*;

  localparam int unsigned MAX_NODES    = 32;
  localparam int unsigned CHUNK_MAX    = 192;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned REPORT_MAX   = 30;
  localparam logic [MASK_W-1:0] NODE_SPACE =
    (MAX_NODES >= 32) ? 32'hFFFF_FFFF : ((32'd1 << MAX_NODES) - 32'd1);

  // Opcodes with no function; the block must ignore them
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    logic [2:0]        op;
    logic [MASK_W-1:0] target_mask;
    logic [SIZE_W-1:0] image_size;
    logic [7:0]        data_byte;
    logic [SIZE_W-1:0] progress;
    logic              success;
    logic [NID_W-1:0]  node_id;
  } campaign_item_t;

  typedef struct {
    logic [2:0]        status;
    logic [2:0]        phase;
    logic [NODE_W-1:0] node;
    logic              pending;
    logic [SIZE_W-1:0] size;
    logic [CRC_W-1:0]  crc;
    logic [SIZE_W-1:0] sent;
    logic              save;
    logic [MASK_W-1:0] done_mask;
    logic [MASK_W-1:0] failed_mask;
    logic [MASK_W-1:0] remaining;
  } campaign_outcome_t;

  // --------------------------------------------------------------------------
  // Campaign scoreboard: shadow state, predicted outcomes, comparison
  // --------------------------------------------------------------------------
  class campaign_scoreboard;
    logic [SIZE_W-1:0]  capacity;
    phase_t             phase;
    logic [MASK_W-1:0]  remaining;
    logic [MASK_W-1:0]  accepted;
    logic [MASK_W-1:0]  refused;
    logic [NODE_W-1:0]  serving;
    logic [SIZE_W-1:0]  size;
    logic [CRC_W-1:0]   crc_latched;
    logic [CRC_W-1:0]   crc_running;
    logic [SIZE_W-1:0]  delivered;
    logic [COUNT_W-1:0] staged;
    campaign_outcome_t  outcome_q[$];
    int unsigned        mismatches;
    int unsigned        noted;
    int unsigned        checked;
    int unsigned        opened;
    int unsigned        completed;
    int unsigned        broken;

    function new();
      capacity    = CAPACITY_RST;
      phase       = PH_IDLE;
      remaining   = '0;
      accepted    = '0;
      refused     = '0;
      serving     = '0;
      size        = '0;
      crc_latched = '0;
      crc_running = '0;
      delivered   = '0;
      staged      = '0;
    endfunction

    // Fold one byte into the CRC, one input bit at a time
    function automatic logic [CRC_W-1:0] fold_crc(logic [CRC_W-1:0] acc,
                                                  logic [7:0] b);
      logic fb;
      for (int k = 7; k >= 0; k--) begin
        fb  = acc[CRC_W-1] ^ b[k];
        acc = {acc[CRC_W-2:0], 1'b0};
        if (fb) begin
          acc = acc ^ CRC_POLY;
        end
      end
      return acc;
    endfunction

    // Serve the lowest remaining target, or close the campaign
    function void select_next_node();
      for (int id = 0; id < MAX_NODES; id++) begin
        if (remaining[id]) begin
          serving   = NODE_W'(id);
          delivered = '0;
          phase     = PH_READY;
          return;
        end
      end
      if (refused == '0) begin
        phase = PH_DONE;
        completed++;
      end else begin
        phase = PH_ERROR;
        broken++;
      end
    endfunction

    // Apply one accepted transaction and queue the outcome it must produce
    function void note_transaction(campaign_item_t it);
      campaign_outcome_t r;
      logic              active;
      logic [MASK_W-1:0] bit_sel;
      r.status = ST_IGNORED;
      r.pending = 1'b0;
      r.save = 1'b0;
      active = (phase == PH_READY) || (phase == PH_SENDING);
      noted++;
      case (it.op)
        OP_START: begin
          if (it.image_size == '0 || it.target_mask == '0 ||
              (it.target_mask & ~NODE_SPACE) != '0) begin
            r.status = ST_INVALID;
          end else if (phase == PH_FETCHING || phase == PH_SENDING) begin
            r.status = ST_BUSY;
          end else if (it.image_size > capacity) begin
            r.status = ST_TOO_BIG;
          end else begin
            phase       = PH_FETCHING;
            remaining   = it.target_mask;
            accepted    = '0;
            refused     = '0;
            serving     = NODE_W'(MAX_NODES);
            size        = it.image_size;
            delivered   = '0;
            crc_running = '0;
            staged      = '0;
            r.save      = 1'b1;
            r.status    = ST_OK;
            opened++;
          end
        end
        OP_BYTE: begin
          if (phase == PH_FETCHING) begin
            crc_running = fold_crc(crc_running, it.data_byte);
            if (staged != STAGED_MAX) begin
              staged++;
            end
            r.status = ST_OK;
          end
        end
        OP_FETCH_END: begin
          if (phase == PH_FETCHING) begin
            r.save = 1'b1;
            if (!it.success) begin
              phase    = PH_ERROR;
              r.status = ST_IO;
              broken++;
            end else if (staged != {1'b0, size}) begin
              phase    = PH_ERROR;
              r.status = ST_INVALID;
              broken++;
            end else begin
              crc_latched = crc_running;
              select_next_node();
              r.status = ST_OK;
            end
          end
        end
        OP_ADVANCE: begin
          if (active && it.progress > delivered) begin
            delivered = it.progress;
            phase     = PH_SENDING;
            if (it.progress[SPAN_BITS-1:0] < CHUNK_MAX || it.progress == size) begin
              r.save = 1'b1;
            end
            r.status = ST_OK;
          end
        end
        OP_FINISH: begin
          if (active) begin
            bit_sel   = (serving < MAX_NODES) ? (32'd1 << serving) : '0;
            remaining = remaining & ~bit_sel;
            if (it.success) begin
              accepted = accepted | bit_sel;
            end else begin
              refused = refused | bit_sel;
            end
            select_next_node();
            r.save   = 1'b1;
            r.status = ST_OK;
          end
        end
        OP_QUERY: begin
          r.pending = active && (serving == {1'b0, it.node_id});
          r.status  = r.pending ? ST_OK : ST_NOT_PENDING;
        end
        default: begin
        end
      endcase
      r.phase       = phase;
      r.node        = serving;
      r.size        = size;
      r.crc         = crc_latched;
      r.sent        = delivered;
      r.done_mask   = accepted;
      r.failed_mask = refused;
      r.remaining   = remaining;
      outcome_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("MISMATCH at %0t ns: %s", $realtime, msg);
      end
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                  checked, name, got, want));
      end
    endtask

    // Compare one accepted result with the oldest prediction
    task check_transaction(campaign_outcome_t got);
      campaign_outcome_t want;
      if (outcome_q.size() == 0) begin
        report_mismatch("result arrived with no transaction outstanding");
        return;
      end
      want = outcome_q.pop_front();
      checked++;
      compare_field("status",         MASK_W'(got.status),  MASK_W'(want.status));
      compare_field("campaign_state", MASK_W'(got.phase),   MASK_W'(want.phase));
      compare_field("current_node",   MASK_W'(got.node),    MASK_W'(want.node));
      compare_field("pending",        MASK_W'(got.pending), MASK_W'(want.pending));
      compare_field("size_out",       MASK_W'(got.size),    MASK_W'(want.size));
      compare_field("crc_out",        MASK_W'(got.crc),     MASK_W'(want.crc));
      compare_field("sent_out",       MASK_W'(got.sent),    MASK_W'(want.sent));
      compare_field("save_request",   MASK_W'(got.save),    MASK_W'(want.save));
      compare_field("done_out",       got.done_mask,   want.done_mask);
      compare_field("failed_out",     got.failed_mask, want.failed_mask);
      compare_field("remaining_out",  got.remaining,   want.remaining);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              cfg_valid      = 1'b0;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_data       = '0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic [2:0]        in_op          = '0;
  logic [MASK_W-1:0] in_target_mask = '0;
  logic [SIZE_W-1:0] in_image_size  = '0;
  logic [7:0]        in_data_byte   = '0;
  logic [SIZE_W-1:0] in_progress    = '0;
  logic              in_success     = 1'b0;
  logic [NID_W-1:0]  in_node_id     = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [2:0]        out_status;
  logic [2:0]        out_campaign_state;
  logic [NODE_W-1:0] out_current_node;
  logic              out_pending;
  logic [SIZE_W-1:0] out_size_out;
  logic [CRC_W-1:0]  out_crc_out;
  logic [SIZE_W-1:0] out_sent_out;
  logic              out_save_request;
  logic [MASK_W-1:0] out_done_out;
  logic [MASK_W-1:0] out_failed_out;
  logic [MASK_W-1:0] out_remaining_out;

  campaign_scoreboard sb = new();

  int unsigned send_idle_pct   = 0;
  int unsigned recv_idle_pct   = 0;
  int unsigned cycle_count     = 0;
  int unsigned capacity_writes = 0;

  update_campaign_sequencer_core #(
    .MAX_NODES (MAX_NODES),
    .CHUNK_MAX (CHUNK_MAX)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_target_mask     (in_target_mask),
    .in_image_size      (in_image_size),
    .in_data_byte       (in_data_byte),
    .in_progress        (in_progress),
    .in_success         (in_success),
    .in_node_id         (in_node_id),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_campaign_state (out_campaign_state),
    .out_current_node   (out_current_node),
    .out_pending        (out_pending),
    .out_size_out       (out_size_out),
    .out_crc_out        (out_crc_out),
    .out_sent_out       (out_sent_out),
    .out_save_request   (out_save_request),
    .out_done_out       (out_done_out),
    .out_failed_out     (out_failed_out),
    .out_remaining_out  (out_remaining_out)
  );

  // Clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Hold off results at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Check every result transaction taken
  always @(posedge clk) begin
    campaign_outcome_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.status      = out_status;
      got.phase       = out_campaign_state;
      got.node        = out_current_node;
      got.pending     = out_pending;
      got.size        = out_size_out;
      got.crc         = out_crc_out;
      got.sent        = out_sent_out;
      got.save        = out_save_request;
      got.done_mask   = out_done_out;
      got.failed_mask = out_failed_out;
      got.remaining   = out_remaining_out;
      sb.check_transaction(got);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic campaign_item_t make_item(logic [2:0] op, logic [MASK_W-1:0] mask,
                                               logic [SIZE_W-1:0] size, logic [7:0] data,
                                               logic [SIZE_W-1:0] prog, logic ok,
                                               logic [NID_W-1:0] nid);
    campaign_item_t it;
    it.op          = op;
    it.target_mask = mask;
    it.image_size  = size;
    it.data_byte   = data;
    it.progress    = prog;
    it.success     = ok;
    it.node_id     = nid;
    return it;
  endfunction

  // Mostly well-formed campaigns following the shadow state, some noise
  function automatic campaign_item_t compose_item();
    campaign_item_t    it;
    int unsigned       roll;
    logic [MASK_W-1:0] m;
    it = make_item(3'($urandom_range(7)), $urandom(), SIZE_W'($urandom()),
                   8'($urandom()), SIZE_W'($urandom()), 1'($urandom_range(1)),
                   NID_W'($urandom()));
    if ($urandom_range(99) < 12) begin
      return it;
    end
    roll = $urandom_range(99);
    case (sb.phase)
      PH_FETCHING: begin
        if (sb.size > 64) begin
          it.op = ($urandom_range(3) == 0) ? OP_FETCH_END : OP_BYTE;
        end else if (sb.staged < {1'b0, sb.size}) begin
          it.op = (roll < 3) ? OP_FETCH_END : OP_BYTE;
        end else begin
          it.op = (roll < 5) ? OP_BYTE : OP_FETCH_END;
        end
        it.success = ($urandom_range(99) < 90);
      end
      PH_READY, PH_SENDING: begin
        if (roll < 45) begin
          it.op = OP_ADVANCE;
          case ($urandom_range(5))
            0, 1: it.progress = SIZE_W'(sb.delivered + $urandom_range(1, 60));
            2:    it.progress = sb.size;
            3:    it.progress = SIZE_W'({$urandom_range(1, 1023), 14'd0} |
                                        $urandom_range(250));
            4:    it.progress = SIZE_W'($urandom());
            default: it.progress = SIZE_W'(sb.delivered - $urandom_range(3));
          endcase
        end else if (roll < 65) begin
          it.op = OP_QUERY;
          if ($urandom_range(99) < 60) begin
            it.node_id = sb.serving[NID_W-1:0];
          end
        end else if (roll < 90) begin
          it.op      = OP_FINISH;
          it.success = ($urandom_range(99) < 80);
        end else begin
          it.op = OP_START;
        end
      end
      default: begin
        it.op = OP_START;
      end
    endcase
    // Shape a start request
    if (it.op == OP_START && roll >= 12) begin
      roll = $urandom_range(99);
      if (roll < 75) begin
        m = '0;
        repeat ($urandom_range(1, 4)) m[NID_W'($urandom_range(MAX_NODES - 1))] = 1'b1;
        it.target_mask = m;
      end else if (roll < 97) begin
        it.target_mask = (roll < 92) ? $urandom() : NODE_SPACE;
      end else begin
        it.target_mask = '0;
      end
      roll = $urandom_range(99);
      if (roll < 78) begin
        it.image_size = SIZE_W'($urandom_range(1, 40));
      end else if (roll < 84) begin
        it.image_size = sb.capacity;
      end else if (roll < 88) begin
        it.image_size = sb.capacity + 1'b1;
      end else if (roll < 96) begin
        it.image_size = SIZE_W'($urandom());
      end else begin
        it.image_size = '0;
      end
    end
    return it;
  endfunction

  // Present one transaction and wait until it is taken
  task automatic send_item(input campaign_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    in_op          <= it.op;
    in_target_mask <= it.target_mask;
    in_image_size  <= it.image_size;
    in_data_byte   <= it.data_byte;
    in_progress    <= it.progress;
    in_success     <= it.success;
    in_node_id     <= it.node_id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_transaction(it);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outcome_q.size() != 0);
  endtask

  task automatic program_capacity(input logic [SIZE_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.capacity = value;
    cfg_valid <= 1'b0;
    capacity_writes++;
  endtask

  // Random campaigns, pausing once halfway until all results are back
  task automatic run_campaigns(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if (n == count / 2) begin
        drain_results();
      end
      send_item(compose_item());
    end
  endtask

  initial begin
    campaign_item_t opening[$];

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 11;
    recv_idle_pct = 77;

    // Ignored and refused transactions from idle
    opening.push_back(make_item(OP_QUERY, '0, '0, '0, '0, 1'b0, 5'd0));
    opening.push_back(make_item(OP_BYTE, '0, '0, 8'hFF, '0, 1'b0, '0));
    opening.push_back(make_item(OP_FETCH_END, '0, '0, '0, '0, 1'b1, '0));
    opening.push_back(make_item(OP_FINISH, '0, '0, '0, '0, 1'b1, '0));
    opening.push_back(make_item(OP_SPARE_6, '1, '1, '1, '1, 1'b1, '1));
    opening.push_back(make_item(OP_SPARE_7, '0, '0, '0, '0, 1'b0, '0));
    opening.push_back(make_item(OP_START, 32'h1, 24'd0, '0, '0, 1'b0, '0));
    opening.push_back(make_item(OP_START, 32'h0, 24'd3, '0, '0, 1'b0, '0));
    opening.push_back(make_item(OP_START, 32'h1, CAPACITY_RST + 1'b1, '0, '0, 1'b0, '0));
    // Two-node campaign with busy refusals on the way
    opening.push_back(make_item(OP_START, 32'h8000_0001, 24'd3, '0, '0, 1'b0, '0));
    opening.push_back(make_item(OP_START, 32'h1, 24'd1, '0, '0, 1'b0, '0));
    opening.push_back(make_item(OP_BYTE, '0, '0, 8'h00, '0, 1'b0, '0));
    opening.push_back(make_item(OP_BYTE, '0, '0, 8'hFF, '0, 1'b0, '0));
    opening.push_back(make_item(OP_BYTE, '0, '0, 8'hA5, '0, 1'b0, '0));
    opening.push_back(make_item(OP_FETCH_END, '0, '0, '0, '0, 1'b1, '0));
    opening.push_back(make_item(OP_QUERY, '0, '0, '0, '0, 1'b0, 5'd0));
    opening.push_back(make_item(OP_ADVANCE, '0, '0, '0, 24'd200, 1'b0, '0));
    opening.push_back(make_item(OP_START, 32'h1, 24'd1, '0, '0, 1'b0, '0));
    opening.push_back(make_item(OP_FINISH, '0, '0, '0, '0, 1'b1, '0));
    opening.push_back(make_item(OP_QUERY, '0, '0, '0, '0, 1'b0, 5'd31));
    opening.push_back(make_item(OP_ADVANCE, '0, '0, '0, 24'd16389, 1'b0, '0));
    opening.push_back(make_item(OP_FINISH, '0, '0, '0, '0, 1'b0, '0));
    // Failed download, then a byte count that falls short
    opening.push_back(make_item(OP_START, 32'h2, 24'd1, '0, '0, 1'b0, '0));
    opening.push_back(make_item(OP_FETCH_END, '0, '0, '0, '0, 1'b0, '0));
    opening.push_back(make_item(OP_START, 32'h4, 24'd1, '0, '0, 1'b0, '0));
    opening.push_back(make_item(OP_FETCH_END, '0, '0, '0, '0, 1'b1, '0));
    foreach (opening[i]) send_item(opening[i]);

    // Random campaigns across capacities and idle patterns
    program_capacity(24'hFF_FFFF);
    run_campaigns(650);
    program_capacity(24'd0);
    run_campaigns(60);
    send_idle_pct = 77;
    recv_idle_pct = 11;
    program_capacity(24'd30);
    run_campaigns(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_capacity(CAPACITY_RST);
    run_campaigns(640);

    // Wind down
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.outcome_q.size() != 0) begin
      sb.report_mismatch($sformatf("%0d results never arrived", sb.outcome_q.size()));
    end
    $display("Sent %0d transactions and checked %0d results under %0d capacity settings",
             sb.noted, sb.checked, capacity_writes);
    $display("Campaigns opened %0d, delivered to all targets %0d, ended in error %0d",
             sb.opened, sb.completed, sb.broken);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
